[hdl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue: command and status
// codes, controller states and the word formats passed along the cell chain.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int CAPACITY    = 16;
   localparam int TIME_BITS   = 32;
   localparam int HANDLE_BITS = 10;

   // request word layout, lowest bit first
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INSERT
   } state_type;

   // one timer slot
   typedef struct packed {
      logic                   valid;
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   expiry;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic ins;   // insert key handle/expiry in sorted place
      logic del;   // remove the matching cell, close the gap
      logic pop;   // remove the head cell
   } op_type;

   // search keys broadcast to every cell
   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   expiry;
      logic [TIME_BITS-1:0]   now;
   } key_type;

endpackage

[hdl/stq_cell.sv]
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain. Compares its entry against the broadcast
// keys and takes its left or right neighbor's entry to open or close a gap.
// ----------------------------------------------------------------------------
module stq_cell (
   input  logic               clock,
   input  logic               reset,
   input  stq_pkg::op_type    op,
   input  stq_pkg::key_type   key,
   input  stq_pkg::entry_type left_q,
   input  logic               left_keep,
   input  stq_pkg::entry_type right_q,
   input  logic               del_in,
   output stq_pkg::entry_type q,
   output logic               keep,
   output logic               match,
   output logic               due,
   output logic               del_out
);

   stq_pkg::entry_type entry_ff;
   stq_pkg::entry_type entry_in;

   assign q = entry_ff;

   // local compares
   assign keep    = entry_ff.valid && (entry_ff.expiry <= key.expiry);
   assign match   = entry_ff.valid && (entry_ff.handle == key.handle);
   assign due     = entry_ff.valid && (entry_ff.expiry <= key.now);
   assign del_out = del_in | match;

   // insert shifts right past the kept prefix; delete and pop shift left
   always_comb begin
      entry_in = entry_ff;
      if (op.ins && !keep) begin
         if (left_keep) begin
            entry_in.valid  = 1'b1;
            entry_in.handle = key.handle;
            entry_in.expiry = key.expiry;
         end else begin
            entry_in = left_q;
         end
      end else if ((op.del && del_out) || op.pop) begin
         entry_in = right_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

[hdl/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Up to CAPACITY timers held in a chain of cells sorted by expiry, with
// add, adjust, delete and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command word; rsp channel returns result words.
//   Add, adjust and delete each return one status word with tlast set.
//   Tick returns one word per expired timer, oldest expiry first, tlast on
//   the final one; with nothing expired it returns a single empty word.
// Sequence:
//   A command is taken in the idle state and executed in the exec state
//   once the result register is free. For adjust of a live timer, the
//   timer is unlinked in exec and then re-inserted in the insert state.
//   Tick pops one expired timer per chain shift, staying in exec while
//   the next cell is due as well. While the result register is free,
//   the chain does one insert or one shift per cycle across all cells.
// Reset clears every slot and leaves the queue empty and idle.
// A stalled rsp side holds the result register; the chain only advances
// when that register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command[1:0], handle[11:2], expire_time[43:12], now[75:44], zero pad
   input  logic [stq_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], expired_valid[2], expired_handle[12:3], zero pad
   output logic [stq_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int CAP = stq_pkg::CAPACITY;
   localparam int HB  = stq_pkg::HANDLE_BITS;
   localparam int TB  = stq_pkg::TIME_BITS;

   // controller and command registers
   stq_pkg::state_type  state_ff, state_in;
   stq_pkg::cmd_type    cmd_ff;
   logic [HB-1:0]       handle_ff;
   logic [TB-1:0]       expire_ff;
   logic [TB-1:0]       now_ff;

   // result register
   logic                rsp_valid_ff;
   stq_pkg::status_type rsp_status_ff;
   logic                rsp_xvalid_ff;
   logic [HB-1:0]       rsp_xhandle_ff;
   logic                rsp_last_ff;

   // controller outputs
   logic                emit;
   stq_pkg::status_type emit_status;
   logic                emit_xvalid;
   logic [HB-1:0]       emit_xhandle;
   logic                emit_last;
   stq_pkg::op_type     op;
   stq_pkg::key_type    key;

   // chain signals
   stq_pkg::entry_type  cell_q    [CAP];
   logic                cell_keep [CAP];
   logic                cell_match[CAP];
   logic                cell_due  [CAP];
   logic [CAP:0]        del_chain;
   logic [CAP-1:0]      match_vec;

   logic                accept;
   logic                out_free;
   logic                found;
   logic                full;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign found      = |match_vec;
   assign full       = cell_q[CAP-1].valid;

   assign key.handle = handle_ff;
   assign key.expiry = expire_ff;
   assign key.now    = now_ff;

   // cell chain
   assign del_chain[0] = 1'b0;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      stq_pkg::entry_type left_q;
      stq_pkg::entry_type right_q;
      logic               left_keep;

      if (i == 0) begin : g_head
         assign left_q    = '0;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_q    = cell_q[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == CAP - 1) begin : g_tail
         assign right_q = '0;
      end else begin : g_next
         assign right_q = cell_q[i+1];
      end

      assign match_vec[i] = cell_match[i];

      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .key       (key),
         .left_q    (left_q),
         .left_keep (left_keep),
         .right_q   (right_q),
         .del_in    (del_chain[i]),
         .q         (cell_q[i]),
         .keep      (cell_keep[i]),
         .match     (cell_match[i]),
         .due       (cell_due[i]),
         .del_out   (del_chain[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = stq_pkg::ST_EXEC;
            end
         end
         stq_pkg::ST_EXEC: begin
            if (out_free) begin
               if (cmd_ff == stq_pkg::CMD_ADJUST && found) begin
                  state_in = stq_pkg::ST_INSERT;
               end else if (cmd_ff == stq_pkg::CMD_TICK && cell_due[0] && cell_due[1]) begin
                  state_in = stq_pkg::ST_EXEC;
               end else begin
                  state_in = stq_pkg::ST_IDLE;
               end
            end
         end
         stq_pkg::ST_INSERT: begin
            if (out_free) begin
               state_in = stq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stq_pkg::ST_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready   = 1'b0;
      op           = '0;
      emit         = 1'b0;
      emit_status  = stq_pkg::STS_OK;
      emit_xvalid  = 1'b0;
      emit_xhandle = '0;
      emit_last    = 1'b1;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         stq_pkg::ST_EXEC: begin
            if (out_free) begin
               case (cmd_ff)
                  stq_pkg::CMD_ADD: begin
                     emit = 1'b1;
                     if (found) begin
                        emit_status = stq_pkg::STS_DUPLICATE;
                     end else if (full) begin
                        emit_status = stq_pkg::STS_FULL;
                     end else begin
                        op.ins = 1'b1;
                     end
                  end
                  stq_pkg::CMD_ADJUST: begin
                     if (found) begin
                        op.del = 1'b1;
                     end else begin
                        emit        = 1'b1;
                        emit_status = stq_pkg::STS_NOT_FOUND;
                     end
                  end
                  stq_pkg::CMD_DELETE: begin
                     emit = 1'b1;
                     if (found) begin
                        op.del = 1'b1;
                     end else begin
                        emit_status = stq_pkg::STS_NOT_FOUND;
                     end
                  end
                  stq_pkg::CMD_TICK: begin
                     emit = 1'b1;
                     if (cell_due[0]) begin
                        op.pop       = 1'b1;
                        emit_xvalid  = 1'b1;
                        emit_xhandle = cell_q[0].handle;
                        emit_last    = !cell_due[1];
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         stq_pkg::ST_INSERT: begin
            if (out_free) begin
               op.ins = 1'b1;
               emit   = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // state and command capture
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= stq_pkg::cmd_type'(req_tdata[1:0]);
         handle_ff <= req_tdata[11:2];
         expire_ff <= req_tdata[43:12];
         now_ff    <= req_tdata[75:44];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff  <= emit_status;
         rsp_xvalid_ff  <= emit_xvalid;
         rsp_xhandle_ff <= emit_xhandle;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_xhandle_ff, rsp_xvalid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
